FILE: hw/rtl/qwpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue with prefix reverse: shared package
// Operation and status codes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package qwpr_pkg;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FEW   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic enq_write;
    logic deq_read;
    logic rev_init;
    logic set_result;
    logic swap_read;
    logic swap_write_a;
    logic swap_write_b;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic enq_ok;
    logic deq_ok;
    logic rev_go;
    logic last_swap;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/qwpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue with prefix reverse: controller
// Sequences one beat at a time through check, swap loop and result hand-off.
// ----------------------------------------------------------------------------
module qwpr_ctrl
  import qwpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.rev_go) state_next = S_SWAP_RD;
        else state_next = S_RESULT;
      end
      S_SWAP_RD: state_next = S_SWAP_WA;
      S_SWAP_WA: state_next = S_SWAP_WB;
      S_SWAP_WB: begin
        if (sts.last_swap) state_next = S_RESULT;
        else state_next = S_SWAP_RD;
      end
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      S_CHECK: begin
        cmd.set_result = 1'b1;
        cmd.enq_write = sts.enq_ok;
        cmd.deq_read = sts.deq_ok;
        cmd.rev_init = sts.rev_go;
      end
      S_SWAP_RD: cmd.swap_read = 1'b1;
      S_SWAP_WA: cmd.swap_write_a = 1'b1;
      S_SWAP_WB: cmd.swap_write_b = 1'b1;
      S_RESULT:  cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/qwpr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue with prefix reverse: datapath
// Ring buffer storage, head pointer and count, swap pointers for the reverse
// walk, and the output register of the result channel.
// ----------------------------------------------------------------------------
module qwpr_dpath
  import qwpr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         operation,
  input  logic signed [31:0] push_value,
  input  logic [7:0]         reverse_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [7:0]         occupancy
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  logic [31:0] mem [DEPTH];

  logic [1:0]       item_op;
  logic [31:0]      item_value;
  logic [7:0]       item_n;
  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] a_ptr;
  logic [PTR_W-1:0] b_ptr;
  logic [6:0]       swaps_left;
  logic [31:0]      rd_a;
  logic [31:0]      rd_b;
  logic [1:0]       res_status;
  logic             res_deq;

  logic             full;
  logic             empty;
  logic             few;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] bend_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] bend;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] a_inc;
  logic [PTR_W-1:0] b_dec;
  logic [PTR_W-1:0] rd_addr_a;
  logic [PTR_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic             wr_en;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign few   = (SUM_W'(item_n) > SUM_W'(count));

  // Both sums stay below twice the depth whenever they are used, so one conditional subtract wraps them.
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign bend_sum = SUM_W'(head) + SUM_W'(item_n) - SUM_W'(1);
  assign tail = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                            : PTR_W'(tail_sum);
  assign bend = (bend_sum >= SUM_W'(DEPTH)) ? PTR_W'(bend_sum - SUM_W'(DEPTH))
                                            : PTR_W'(bend_sum);

  assign head_inc = (head == LAST_IDX) ? '0 : head + PTR_W'(1);
  assign a_inc    = (a_ptr == LAST_IDX) ? '0 : a_ptr + PTR_W'(1);
  assign b_dec    = (b_ptr == '0) ? LAST_IDX : b_ptr - PTR_W'(1);

  assign sts.enq_ok    = (item_op == OP_ENQ) && !full;
  assign sts.deq_ok    = (item_op == OP_DEQ) && !empty;
  assign sts.rev_go    = (item_op == OP_REV) && !few && (item_n[7:1] != '0);
  assign sts.last_swap = (swaps_left == 7'd1);
  assign sts.out_free  = !out_valid || out_ready;

  // Memory: one write port, two registered read ports.
  assign rd_addr_a = cmd.deq_read ? head : a_ptr;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = a_ptr;
    wr_data = rd_b;
    if (cmd.enq_write) begin
      wr_addr = tail;
      wr_data = item_value;
    end else if (cmd.swap_write_b) begin
      wr_addr = b_ptr;
      wr_data = rd_a;
    end else if (!cmd.swap_write_a) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.deq_read || cmd.swap_read) rd_a <= mem[rd_addr_a];
    if (cmd.swap_read) rd_b <= mem[b_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op    <= operation;
      item_value <= push_value;
      item_n     <= reverse_count;
    end
    if (cmd.rev_init) begin
      a_ptr      <= head;
      b_ptr      <= bend;
      swaps_left <= item_n[7:1];
    end else if (cmd.swap_write_b) begin
      a_ptr      <= a_inc;
      b_ptr      <= b_dec;
      swaps_left <= swaps_left - 7'd1;
    end
    if (cmd.set_result) begin
      res_deq <= sts.deq_ok;
      case (item_op)
        OP_ENQ:  res_status <= full ? ST_FULL : ST_OK;
        OP_DEQ:  res_status <= empty ? ST_EMPTY : ST_OK;
        OP_REV:  res_status <= few ? ST_FEW : ST_OK;
        default: res_status <= ST_OK;
      endcase
    end
    if (cmd.load_out) begin
      read_value <= res_deq ? rd_a : '0;
      status     <= res_status;
      occupancy  <= 8'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.enq_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.deq_read) begin
        count <= count - CNT_W'(1);
        head  <= head_inc;
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.enq_write, cmd.deq_read, cmd.swap_write_a, cmd.swap_write_b}))
    else $error("conflicting storage commands");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_read |=> (count == $past(count) - CNT_W'(1)))
    else $error("dequeue did not lower the count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("result register overwritten before it was taken");

endmodule

FILE: hw/rtl/queue_with_prefix_reverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue with prefix reverse: top level
// FIFO of signed 32-bit words with enqueue, dequeue and reverse-first-n.
// ----------------------------------------------------------------------------
// The block handles one beat at a time and returns one result beat for each.
// An enqueue, a dequeue, a rejected operation and a reverse of fewer than two
// entries go through accept, check and loading of the result register, in
// that order. A reverse of n entries swaps them in place in the ring buffer,
// one swap at a time (read both ends, write the head side, write the tail
// side), floor(n / 2) swaps in all; the single write port of the storage is
// why each swap writes its two sides separately. A finished result sits in the
// output register while the next beat is accepted; if it has not been taken
// when the next result is ready, the block waits until it is.
module queue_with_prefix_reverse_top
  import qwpr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] push_value,
  input  logic [7:0]         reverse_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [7:0]         occupancy
);

  cmd_t cmd;
  sts_t sts;

  qwpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qwpr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .push_value    (push_value),
    .reverse_count (reverse_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_value    (read_value),
    .status        (status),
    .occupancy     (occupancy)
  );

endmodule
